// ===== design/teq_pkg.sv =====
// Shared types and constants of the timed event queue.
// Used by teq_div1000 and timed_event_queue_top; depends on nothing else.
package teq_pkg;

    // Queue geometry. Every address and count width follows from the depth.
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    // Stream word layout.
    localparam int IN_DATA_W   = 224;
    localparam int OUT_DATA_W  = 120;
    localparam int FIRE_MS_W   = 55;

    // Fixed due times and the unit scale.
    localparam logic signed [63:0] DUE_FRONT   = 64'sh8000_0000_0000_0001;
    localparam logic signed [63:0] DUE_BACK    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] DUE_MIN     = 64'sh8000_0000_0000_0000;
    localparam int                 US_PER_MS   = 1000;
    localparam int                 DLY_PROD_W  = 43;

    // Constant divider: a few quotient bits per clock.
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = 64 / DIV_BITS_PER_STEP;
    localparam int DIV_REM_W         = $clog2(US_PER_MS);
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        CMD_POST_FRONT = 3'd0,
        CMD_POST_BACK  = 3'd1,
        CMD_POST_DELAY = 3'd2,
        CMD_POST_AT    = 3'd3,
        CMD_CANCEL     = 3'd4,
        CMD_TICK       = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_POSTED    = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_CANCELLED = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FIRED     = 3'd4,
        STAT_NOTHING   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_HEAD,
        S_CAN_CMP,
        S_TICK_CMP,
        S_SHIFT,
        S_FINISH
    } t_state;

    // One queue entry as it sits in the entry memory.
    typedef struct packed {
        logic [63:0] due;
        logic [31:0] id;
        logic [31:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== design/teq_ram.sv =====
// Simple dual-port entry memory: one write port, one read port, registered read data.
// Generic; no package dependency.
module teq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/teq_div1000.sv =====
// Signed divide of a 64-bit microsecond time by 1000, truncating toward zero.
// Restoring division, a few bits per clock; uses teq_pkg.
module teq_div1000 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [63:0]             i_dividend,
    output logic                           o_done,
    output logic signed [teq_pkg::FIRE_MS_W-1:0] o_quotient
);
    import teq_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_neg;
    logic [63:0]           r_mag;
    logic [DIV_REM_W-1:0]  r_rem;

    logic [63:0]           n_mag;
    logic [DIV_REM_W-1:0]  n_rem;
    logic [FIRE_MS_W-1:0]  quot;

    // The magnitude register shifts dividend bits out at the top and
    // quotient bits in at the bottom; after the last step it holds the quotient.
    always_comb begin
        logic [DIV_REM_W:0] trial;
        n_mag = r_mag;
        n_rem = r_rem;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            trial = {n_rem, n_mag[63]};
            n_mag = {n_mag[62:0], 1'b0};
            if (trial >= (DIV_REM_W + 1)'(US_PER_MS)) begin
                n_rem    = DIV_REM_W'(trial - (DIV_REM_W + 1)'(US_PER_MS));
                n_mag[0] = 1'b1;
            end else begin
                n_rem = trial[DIV_REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_mag <= i_dividend[63] ? (64'd0 - i_dividend) : i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    assign quot       = r_mag[FIRE_MS_W-1:0];
    assign o_done     = r_done;
    assign o_quotient = r_neg ? signed'(FIRE_MS_W'(0) - quot) : signed'(quot);

endmodule

// ===== design/timed_event_queue_top.sv =====
// Timed event queue: sequencer, entry memory and output register.
// Uses teq_pkg, teq_ram and teq_div1000.
//
// The queue holds up to 16 events sorted by due time in one entry memory
// (due time, id, handle per row) that is read and written one row per clock.
// One command word is handled at a time: a post walks from the tail toward
// the insertion point, moving each later entry up one row, and passes
// through an extra head state if it lands at the head; a cancel reads ids
// from the head until it finds the match and then moves every later entry
// down; a tick that fires is bound by the divide of now_us by 1000, which
// starts when the command is accepted, and its head removal moves entry
// count - 1 rows in parallel with it. Posts to a full queue, cancels of id 0
// and ticks on an empty queue go straight from decode to the finish state.
// The output register lets the next command word be taken while a result
// word still waits on the master side; s_axis_tready is high whenever the
// sequencer is idle. Command codes 6 and 7 are consumed with no result word.
module timed_event_queue_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // s_axis_tdata, from bit 0: event_handle[31:0], time_us[63:0],
    // delay_ms[31:0], cancel_id[31:0], now_us[63:0].
    input  logic [teq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // s_axis_tuser: cmd[2:0].
    input  logic [2:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // m_axis_tdata, from bit 0: event_id[31:0], fired_handle[31:0],
    // fire_time_ms[54:0], then zero fill.
    output logic [teq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // m_axis_tuser: status[2:0].
    output logic [2:0]                        m_axis_tuser
);
    import teq_pkg::*;

    // Input word fields.
    logic [31:0]          s_handle;
    logic signed [63:0]   s_time;
    logic signed [31:0]   s_delay;
    logic [31:0]          s_cancel;
    logic signed [63:0]   s_now;
    logic                 in_acc;
    logic                 cmd_known;

    assign s_handle = s_axis_tdata[31:0];
    assign s_time   = signed'(s_axis_tdata[95:32]);
    assign s_delay  = signed'(s_axis_tdata[127:96]);
    assign s_cancel = s_axis_tdata[159:128];
    assign s_now    = signed'(s_axis_tdata[223:160]);

    t_state                   r_state, n_state;
    t_cmd                     r_cmd;
    logic [31:0]              r_handle;
    logic signed [63:0]       r_time;
    logic signed [DLY_PROD_W-1:0] r_prod;
    logic [31:0]              r_cancel;
    logic signed [63:0]       r_now;
    logic signed [63:0]       r_due;
    logic [Q_AW-1:0]          r_k;
    logic [Q_CW-1:0]          r_count;
    logic [31:0]              r_next_id, n_next_id;
    t_status                  r_res_status;
    logic [31:0]              r_res_id;
    logic [31:0]              r_res_handle;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [31:0]              r_out_id;
    logic [31:0]              r_out_handle;
    logic signed [FIRE_MS_W-1:0] r_out_ms;

    // Entry memory ports.
    logic                     wr_en, rd_en;
    logic [Q_AW-1:0]          wr_addr, rd_addr;
    t_entry                   wr_data, rd_data, new_entry;

    // Divider.
    logic                     div_start, div_done;
    logic signed [FIRE_MS_W-1:0] div_quot;

    // Shared decisions of the sequencer.
    logic [Q_CW-1:0]          k_plus1;
    logic [Q_CW:0]            k_plus2;
    logic [Q_AW-1:0]          rm_idx;
    logic signed [63:0]       rd_due;
    logic signed [64:0]       dly_sum;
    logic signed [63:0]       due_sel;
    logic                     ins_stop, can_match, can_more, fire_now;
    logic                     rm_more, shift_more, fin_go, q_full;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        unique case (s_axis_tuser) inside
            CMD_POST_FRONT, CMD_POST_BACK, CMD_POST_DELAY,
            CMD_POST_AT, CMD_CANCEL, CMD_TICK: cmd_known = 1'b1;
            default:                           cmd_known = 1'b0;
        endcase
    end

    assign div_start = in_acc && (s_axis_tuser == CMD_TICK);

    teq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    teq_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (s_now),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // The delayed due time saturates when the 64-bit add overflows.
    assign dly_sum = 65'(r_now) + 65'(r_prod);

    always_comb begin
        case (r_cmd)
            CMD_POST_FRONT: due_sel = DUE_FRONT;
            CMD_POST_BACK:  due_sel = DUE_BACK;
            CMD_POST_DELAY: begin
                if (dly_sum[64] != dly_sum[63]) begin
                    due_sel = dly_sum[64] ? DUE_MIN : DUE_BACK;
                end else begin
                    due_sel = dly_sum[63:0];
                end
            end
            default:        due_sel = r_time;
        endcase
    end

    assign new_entry = '{due: r_due, id: r_next_id, handle: r_handle};
    assign rd_due    = signed'(rd_data.due);
    assign q_full    = (r_count == Q_CW'(QUEUE_DEPTH));

    always_comb begin
        k_plus1    = Q_CW'(r_k) + Q_CW'(1);
        k_plus2    = (Q_CW + 1)'(r_k) + (Q_CW + 1)'(2);
        // The new entry goes after every entry whose due time is equal or earlier.
        ins_stop   = (r_due >= rd_due);
        can_match  = (rd_data.id == r_cancel);
        can_more   = (k_plus1 < r_count);
        // Negative and end-of-time due values fire on any tick.
        fire_now   = (rd_due < 64'sd0) || (rd_due == DUE_BACK) || (rd_due <= r_now);
        rm_idx     = (r_state == S_TICK_CMP) ? '0 : r_k;
        rm_more    = ((Q_CW'(rm_idx) + Q_CW'(1)) < r_count);
        shift_more = (k_plus2 < {1'b0, r_count});
        fin_go     = ((r_res_status != STAT_FIRED) || div_done)
                     && (!r_out_valid || m_axis_tready);
        // The id counter never hands out zero.
        n_next_id  = (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && cmd_known) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd) inside
                    CMD_POST_FRONT, CMD_POST_BACK, CMD_POST_DELAY, CMD_POST_AT:
                        n_state = q_full ? S_FINISH : S_INS_RD;
                    CMD_CANCEL:
                        n_state = ((r_cancel == 32'd0) || (r_count == '0)) ?
                                  S_FINISH : S_CAN_CMP;
                    CMD_TICK:
                        n_state = (r_count == '0) ? S_FINISH : S_TICK_CMP;
                    default:
                        n_state = S_IDLE;
                endcase
            end
            S_INS_RD: begin
                n_state = (r_count == '0) ? S_FINISH : S_INS_CMP;
            end
            S_INS_CMP: begin
                if (ins_stop) begin
                    n_state = S_FINISH;
                end else if (r_k == '0) begin
                    n_state = S_INS_HEAD;
                end
            end
            S_INS_HEAD: begin
                n_state = S_FINISH;
            end
            S_CAN_CMP: begin
                if (can_match) begin
                    n_state = rm_more ? S_SHIFT : S_FINISH;
                end else if (!can_more) begin
                    n_state = S_FINISH;
                end
            end
            S_TICK_CMP: begin
                n_state = (fire_now && rm_more) ? S_SHIFT : S_FINISH;
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory accesses. A read issued in one state is consumed in the next,
    // and writes trail the reads by one row, so no row is read after it moved.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = new_entry;
        unique case (r_state)
            S_DECODE: begin
                if ((r_cmd == CMD_CANCEL) || (r_cmd == CMD_TICK)) begin
                    rd_en = 1'b1;
                end
            end
            S_INS_RD: begin
                if (r_count == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_k;
                end
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = Q_AW'(k_plus1);
                if (!ins_stop) begin
                    wr_data = rd_data;
                    if (r_k != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = r_k - Q_AW'(1);
                    end
                end
            end
            S_INS_HEAD: begin
                wr_en = 1'b1;
            end
            S_CAN_CMP: begin
                rd_en   = can_match ? rm_more : can_more;
                rd_addr = Q_AW'(k_plus1);
            end
            S_TICK_CMP: begin
                rd_en   = fire_now && rm_more;
                rd_addr = Q_AW'(1);
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = rd_data;
                if (shift_more) begin
                    rd_en   = 1'b1;
                    rd_addr = Q_AW'(k_plus2);
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_id   <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            case (r_state)
                S_INS_RD: begin
                    if (r_count == '0) begin
                        r_count   <= r_count + Q_CW'(1);
                        r_next_id <= n_next_id;
                    end
                end
                S_INS_CMP: begin
                    if (ins_stop) begin
                        r_count   <= r_count + Q_CW'(1);
                        r_next_id <= n_next_id;
                    end
                end
                S_INS_HEAD: begin
                    r_count   <= r_count + Q_CW'(1);
                    r_next_id <= n_next_id;
                end
                S_CAN_CMP: begin
                    if (can_match && !rm_more) begin
                        r_count <= r_count - Q_CW'(1);
                    end
                end
                S_TICK_CMP: begin
                    if (fire_now && !rm_more) begin
                        r_count <= r_count - Q_CW'(1);
                    end
                end
                S_SHIFT: begin
                    if (!shift_more) begin
                        r_count <= r_count - Q_CW'(1);
                    end
                end
                default: begin
                end
            endcase

            if ((r_state == S_FINISH) && fin_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_cmd    <= t_cmd'(s_axis_tuser);
                    r_handle <= s_handle;
                    r_time   <= s_time;
                    r_prod   <= DLY_PROD_W'(s_delay) * DLY_PROD_W'(US_PER_MS);
                    r_cancel <= s_cancel;
                    r_now    <= s_now;
                end
            end
            S_DECODE: begin
                r_due        <= due_sel;
                r_res_handle <= 32'd0;
                case (r_cmd) inside
                    CMD_POST_FRONT, CMD_POST_BACK, CMD_POST_DELAY, CMD_POST_AT: begin
                        r_res_status <= q_full ? STAT_FULL : STAT_POSTED;
                        r_res_id     <= q_full ? 32'd0 : r_next_id;
                        r_k          <= Q_AW'(r_count - Q_CW'(1));
                    end
                    CMD_CANCEL: begin
                        r_res_status <= STAT_NOT_FOUND;
                        r_res_id     <= r_cancel;
                        r_k          <= '0;
                    end
                    default: begin
                        r_res_status <= STAT_NOTHING;
                        r_res_id     <= 32'd0;
                        r_k          <= '0;
                    end
                endcase
            end
            S_INS_CMP: begin
                r_k <= r_k - Q_AW'(1);
            end
            S_CAN_CMP: begin
                if (can_match) begin
                    r_res_status <= STAT_CANCELLED;
                end else if (can_more) begin
                    r_k <= Q_AW'(k_plus1);
                end
            end
            S_TICK_CMP: begin
                if (fire_now) begin
                    r_res_status <= STAT_FIRED;
                    r_res_id     <= rd_data.id;
                    r_res_handle <= rd_data.handle;
                    r_k          <= '0;
                end
            end
            S_SHIFT: begin
                if (shift_more) begin
                    r_k <= Q_AW'(k_plus1);
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    r_out_status <= r_res_status;
                    r_out_id     <= r_res_id;
                    r_out_handle <= r_res_handle;
                    r_out_ms     <= (r_res_status == STAT_FIRED) ? div_quot : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(OUT_DATA_W - 64 - FIRE_MS_W)'(0), r_out_ms,
                            r_out_handle, r_out_id};

endmodule
